FILE: design/peqbq_pkg.sv
// ----------------------------------------------------------------------------
// peqbq_pkg: shared types and constants for the peaking EQ biquad
// Fixed widths of the coefficient path, register indexes and accumulator
// control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package peqbq_pkg;

  localparam int COEF_BITS     = 32;
  localparam int MID_BITS      = 40;
  // five coefficients summed at one bit position
  localparam int SUM_BITS      = COEF_BITS + 3;
  // running upper part of the shift-add accumulator
  localparam int ACC_HI_BITS   = MID_BITS + 1;
  localparam int TERM_BITS     = ACC_HI_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A0 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd5;

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctl_t;

endpackage

`default_nettype wire

FILE: design/peaking_eq_biquad_top.sv
// ----------------------------------------------------------------------------
// peaking_eq_biquad_top: direct-form-I peaking EQ biquad, bit-serial
// Serial multiply: one sample bit per cycle, then one gain bit per cycle.
// The input is stalled from accept until the item leaves ST_FIN.
// A finished item waits in the output register while the next one runs.
// Reset (rst_n low, sync): coefs to pass-through, history to zero, idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peaking_eq_biquad_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample_in,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_sample_out,
  output logic                                        out_clipped,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [peqbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [peqbq_pkg::COEF_BITS-1:0]        cfg_wdata
);
  import peqbq_pkg::*;

  localparam int LO_BITS   = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
  localparam int CNT_BITS  = $clog2(LO_BITS);
  localparam int ACC1_BITS = SUM_BITS + SAMPLE_BITS;
  localparam int EXT1_BITS = ACC1_BITS + MID_BITS;
  localparam int PROD_BITS = ACC_HI_BITS + COEF_BITS;
  localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic signed [MID_BITS-1:0] MID_MAX = {1'b0, {(MID_BITS-1){1'b1}}};
  localparam logic signed [MID_BITS-1:0] MID_MIN = {1'b1, {(MID_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MID,
    ST_GAIN,
    ST_FIN
  } state_t;

  state_t state_r;
  logic [CNT_BITS-1:0] cnt_r;

  logic signed [COEF_BITS-1:0] coef_b0_r, coef_b1_r, coef_b2_r;
  logic signed [COEF_BITS-1:0] coef_a0_r, coef_a1_r, coef_a2_r;

  // sample words rotate one bit per cycle during the MAC pass
  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r, y1_r, y2_r;
  logic signed [MID_BITS-1:0]    mid_r;
  logic        [COEF_BITS-1:0]   mul_r;
  logic                          clip_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clipped_r;

  acc_ctl_t                      acc_ctl;
  logic signed [TERM_BITS-1:0]   term;
  logic signed [ACC_HI_BITS-1:0] acc_hi;
  logic        [LO_BITS-1:0]     acc_lo;

  logic                          last_bit;
  logic                          in_fire;
  logic                          fin_fire;
  logic signed [SUM_BITS-1:0]    t_b0, t_b1, t_b2, t_a1, t_a2, sel_sum;

  logic        [ACC1_BITS-1:0]   full1;
  logic signed [EXT1_BITS-1:0]   mid_sh;
  logic        [EXT1_BITS-MID_BITS:0] mid_top;
  logic                          mid_ovf;
  logic signed [MID_BITS-1:0]    mid_nxt;

  logic        [PROD_BITS-1:0]   full2;
  logic signed [PROD_BITS-1:0]   prod_sh;
  logic        [PROD_BITS-SAMPLE_BITS:0] y_top;
  logic                          y_ovf;
  logic signed [SAMPLE_BITS-1:0] y_nxt;

  assign last_bit = (cnt_r == '0);
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign fin_fire = (state_r == ST_FIN) && !(out_valid_r && out_stall);

  assign acc_ctl.clear = in_fire || (state_r == ST_MID);
  assign acc_ctl.step  = (state_r == ST_MAC) || (state_r == ST_GAIN);

  // one bit position of all five products at once
  always_comb begin
    t_b0 = SUM_BITS'(coef_b0_r);
    t_b1 = SUM_BITS'(coef_b1_r);
    t_b2 = SUM_BITS'(coef_b2_r);
    t_a1 = SUM_BITS'(coef_a1_r);
    t_a2 = SUM_BITS'(coef_a2_r);
    if (!x_r[0])  t_b0 = '0;
    if (!x1_r[0]) t_b1 = '0;
    if (!x2_r[0]) t_b2 = '0;
    if (!y1_r[0]) t_a1 = '0;
    if (!y2_r[0]) t_a2 = '0;
    sel_sum = t_b0 + t_b1 + t_b2 + t_a1 + t_a2;
  end

  // sign bit of the serial operand carries negative weight
  always_comb begin
    term = '0;
    if (state_r == ST_MAC) begin
      term = TERM_BITS'(sel_sum);
    end else if (mul_r[0]) begin
      term = TERM_BITS'(mid_r);
    end
    if (last_bit) begin
      term = -term;
    end
  end

  peqbq_shift_acc #(
    .LO_BITS (LO_BITS)
  ) u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .term   (term),
    .acc_hi (acc_hi),
    .acc_lo (acc_lo)
  );

  // floor shift and saturate the five-tap sum to the intermediate width
  always_comb begin
    full1   = {acc_hi[SUM_BITS-1:0], acc_lo[LO_BITS-1 -: SAMPLE_BITS]};
    mid_sh  = $signed({{MID_BITS{full1[ACC1_BITS-1]}}, full1}) >>> COEF_FRAC_BITS;
    mid_top = mid_sh[EXT1_BITS-1:MID_BITS-1];
    mid_ovf = !((&mid_top) || !(|mid_top));
    if (mid_ovf) begin
      mid_nxt = mid_sh[EXT1_BITS-1] ? MID_MIN : MID_MAX;
    end else begin
      mid_nxt = mid_sh[MID_BITS-1:0];
    end
  end

  // gain product, floor shift, saturate to the sample width
  always_comb begin
    full2   = {acc_hi, acc_lo[LO_BITS-1 -: COEF_BITS]};
    prod_sh = $signed(full2) >>> COEF_FRAC_BITS;
    y_top   = prod_sh[PROD_BITS-1:SAMPLE_BITS-1];
    y_ovf   = !((&y_top) || !(|y_top));
    if (y_ovf) begin
      y_nxt = prod_sh[PROD_BITS-1] ? OUT_MIN : OUT_MAX;
    end else begin
      y_nxt = prod_sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      coef_b0_r   <= COEF_UNITY;
      coef_b1_r   <= '0;
      coef_b2_r   <= '0;
      coef_a0_r   <= COEF_UNITY;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_B0:  coef_b0_r <= cfg_wdata;
          REG_B1:  coef_b1_r <= cfg_wdata;
          REG_B2:  coef_b2_r <= cfg_wdata;
          REG_A0:  coef_a0_r <= cfg_wdata;
          REG_A1:  coef_a1_r <= cfg_wdata;
          REG_A2:  coef_a2_r <= cfg_wdata;
          default: ;
        endcase
      end

      out_valid_r <= (out_valid_r && out_stall) || fin_fire;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            x_r     <= in_sample_in;
            clip_r  <= 1'b0;
            cnt_r   <= CNT_BITS'(SAMPLE_BITS - 1);
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          // the full rotation leaves every word restored at the end of the MAC pass
          x_r   <= {x_r[0],  x_r[SAMPLE_BITS-1:1]};
          x1_r  <= {x1_r[0], x1_r[SAMPLE_BITS-1:1]};
          x2_r  <= {x2_r[0], x2_r[SAMPLE_BITS-1:1]};
          y1_r  <= {y1_r[0], y1_r[SAMPLE_BITS-1:1]};
          y2_r  <= {y2_r[0], y2_r[SAMPLE_BITS-1:1]};
          cnt_r <= cnt_r - 1'b1;
          if (last_bit) begin
            state_r <= ST_MID;
          end
        end
        ST_MID: begin
          mid_r   <= mid_nxt;
          clip_r  <= clip_r | mid_ovf;
          mul_r   <= coef_a0_r;
          cnt_r   <= CNT_BITS'(COEF_BITS - 1);
          state_r <= ST_GAIN;
        end
        ST_GAIN: begin
          mul_r <= {1'b0, mul_r[COEF_BITS-1:1]};
          cnt_r <= cnt_r - 1'b1;
          if (last_bit) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            out_sample_r  <= y_nxt;
            out_clipped_r <= clip_r | y_ovf;
            x1_r          <= x_r;
            x2_r          <= x1_r;
            y1_r          <= y_nxt;
            y2_r          <= y1_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

`default_nettype wire

FILE: design/peqbq_shift_acc.sv
// ----------------------------------------------------------------------------
// peqbq_shift_acc: LSB-first shift-add accumulator
// While step is set, adds one signed term per cycle into the upper part and
// shifts the settled low bit out into a serial low word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peqbq_shift_acc #(
  parameter int LO_BITS = 32
) (
  input  wire logic                                     clk,
  input  wire peqbq_pkg::acc_ctl_t                      ctl,
  input  wire logic signed [peqbq_pkg::TERM_BITS-1:0]   term,
  output logic signed [peqbq_pkg::ACC_HI_BITS-1:0]      acc_hi,
  output logic        [LO_BITS-1:0]                     acc_lo
);
  import peqbq_pkg::*;

  logic signed [ACC_HI_BITS-1:0] hi_r;
  logic        [LO_BITS-1:0]     lo_r;
  logic signed [TERM_BITS-1:0]   sum;

  assign sum = TERM_BITS'(hi_r) + term;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hi_r <= '0;
    end else if (ctl.step) begin
      hi_r <= sum[TERM_BITS-1:1];
      lo_r <= {sum[0], lo_r[LO_BITS-1:1]};
    end
  end

  assign acc_hi = hi_r;
  assign acc_lo = lo_r;

endmodule

`default_nettype wire

FILE: design/peqbq_chk.sv
// ----------------------------------------------------------------------------
// peqbq_chk: port-level checks for the peaking EQ biquad
// Watches the top level's channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peqbq_chk #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input wire logic                          out_clipped
);

  // block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // serial datapath never finishes right after an input accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared right after input accept");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_out) && $stable(out_clipped))
    else $error("output item changed while stalled");

endmodule

bind peaking_eq_biquad_top peqbq_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_peqbq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);

`default_nettype wire
